/* rtl/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, opcodes, status codes and widths of the stack-machine executor.
// ----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int REG_COUNT_DEF   = 6;
    localparam int WORD_BITS_DEF   = 32;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = 3;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 9;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_SET  = 3'd2,
        OP_ADD  = 3'd3,
        OP_DIV  = 3'd4,
        OP_AND  = 3'd5,
        OP_HLT  = 3'd6,
        OP_NOP  = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_UNDER = 3'd1,
        STAT_OVER  = 3'd2,
        STAT_DIVZ  = 3'd3,
        STAT_HALT  = 3'd4
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] operand_value;
        logic [IDX_W-1:0]          reg_index;
    } instr_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      pop_valid;
        logic signed [VALUE_W-1:0] out_value;
        logic [DEPTH_W-1:0]        depth_now;
    } result_t;

endpackage

`default_nettype wire

/* rtl/smx_instr_if.sv */
// ----------------------------------------------------------------------------
// smx_instr_if
// Valid/ready channel that carries one instruction item.
// ----------------------------------------------------------------------------
`default_nettype none

interface smx_instr_if;
    import smx_pkg::*;

    logic   valid;
    logic   ready;
    instr_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/smx_result_if.sv */
// ----------------------------------------------------------------------------
// smx_result_if
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface smx_result_if;
    import smx_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/stack_machine_executor_unit.sv */
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// Executes one stack-machine instruction per item. The stack lives in a
// single-port-read synchronous RAM with the top word cached in a register;
// a divide runs on a restoring radix-2 divider.
// ----------------------------------------------------------------------------
// Flow: on accept the word under the top is read from RAM, then the item
//   executes in ST_EXEC and its result is registered; a DIV waits in ST_DIVW.
// No new item is taken before the last commits; a full output register stalls it.
// A finished result waits in the output register while the next item is taken.
// Reset clears the stack count, halt flag and register file; RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_executor_unit #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int REG_COUNT   = smx_pkg::REG_COUNT_DEF,
    parameter int WORD_BITS   = smx_pkg::WORD_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    smx_instr_if.sink    instr,
    smx_result_if.source result
);
    import smx_pkg::*;

    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DIVW = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 halted_reg, halted_next;
    logic [WORD_BITS-1:0] top_reg, top_next;
    instr_t               op_reg;
    logic                 res_valid_reg;
    result_t              res_data_reg, res_next;
    logic [WORD_BITS-1:0] reg_file_reg [REG_COUNT];

    logic [WORD_BITS-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic                 accept;
    logic                 out_free;
    logic                 commit;
    logic                 push_write;
    logic                 reg_we;
    logic                 div_start;
    logic                 div_done;
    logic [WORD_BITS-1:0] div_q;
    logic [WORD_BITS-1:0] imm_word;
    logic [RIW-1:0]       reg_addr;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 stack_full;
    logic                 has_one;
    logic                 has_two;

    assign instr.ready = (state_reg == ST_IDLE);
    assign accept      = instr.valid && instr.ready;
    assign out_free    = !res_valid_reg || result.ready;

    // immediate: sign-extend from 32 bits, then cut to the word size
    assign imm_word = WORD_BITS'({{WORD_BITS{op_reg.operand_value[VALUE_W-1]}},
                                  op_reg.operand_value});
    assign reg_addr = RIW'({{RIW{1'b0}}, op_reg.reg_index});

    assign stack_full = (count_reg == CW'(STACK_DEPTH));
    assign has_one    = (count_reg != '0);
    assign has_two    = (count_reg >= CW'(2));

    // RAM holds entries below the top; the top word stays in top_reg
    assign rd_addr = AW'(count_reg - CW'(2));
    assign wr_addr = AW'(count_reg - CW'(1));

    smx_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (top_reg),
        .divisor  (rd_data_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        top_next    = top_reg;
        commit      = 1'b0;
        push_write  = 1'b0;
        reg_we      = 1'b0;
        div_start   = 1'b0;
        res_next    = '0;
        res_next.status = STAT_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (halted_reg)
                begin
                    res_next.status = STAT_HALT;
                end
                else
                begin
                    unique case (op_reg.func)
                        OP_PUSH:
                        begin
                            if (stack_full)
                            begin
                                res_next.status = STAT_OVER;
                            end
                            else
                            begin
                                push_write = has_one;
                                top_next   = imm_word;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (!has_one)
                            begin
                                res_next.status = STAT_UNDER;
                            end
                            else
                            begin
                                res_next.pop_valid = 1'b1;
                                res_next.out_value = VALUE_W'({{VALUE_W{1'b0}}, top_reg});
                                top_next   = rd_data_reg;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_SET:
                        begin
                            reg_we = (32'(op_reg.reg_index) < REG_COUNT);
                        end
                        OP_ADD, OP_AND, OP_DIV:
                        begin
                            if (!has_two)
                            begin
                                res_next.status = STAT_UNDER;
                            end
                            else if (op_reg.func == OP_ADD)
                            begin
                                top_next   = top_reg + rd_data_reg;
                                count_next = count_reg - 1'b1;
                            end
                            else if (op_reg.func == OP_AND)
                            begin
                                top_next   = {{(WORD_BITS-1){1'b0}},
                                              (top_reg != '0) && (rd_data_reg != '0)};
                                count_next = count_reg - 1'b1;
                            end
                            else if (rd_data_reg == '0)
                            begin
                                res_next.status = STAT_DIVZ;
                            end
                            else
                            begin
                                div_start = 1'b1;
                            end
                        end
                        OP_HLT:
                        begin
                            halted_next = 1'b1;
                        end
                        OP_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (div_start)
                begin
                    state_next = ST_DIVW;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIVW:
            begin
                top_next   = div_q;
                count_next = count_reg - 1'b1;
                if (div_done && out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_next.depth_now = DEPTH_W'({{DEPTH_W{1'b0}}, count_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                reg_file_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg  <= count_next;
                halted_reg <= halted_next;
                if (reg_we)
                begin
                    reg_file_reg[reg_addr] <= imm_word;
                end
            end
            if (commit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= instr.data;
        end
        if (commit)
        begin
            top_reg      <= top_next;
            res_data_reg <= res_next;
        end
    end

    // stack RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (commit && push_write)
        begin
            stack_mem[wr_addr] <= top_reg;
        end
        if (accept)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_count_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("stack count moved without a commit");

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.pop_valid |-> res_data_reg.status == STAT_OK)
        else $error("popped word with an error status");

    a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.status == STAT_HALT |-> halted_reg)
        else $error("halted status while running");

endmodule

`default_nettype wire

/* rtl/smx_div.sv */
// ----------------------------------------------------------------------------
// smx_div
// Signed divider, truncating toward zero. Restoring radix-2, one quotient bit
// per cycle; the result holds with done high until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_div #(
    parameter int WORD_BITS = smx_pkg::WORD_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [WORD_BITS-1:0] dividend,
    input  wire logic [WORD_BITS-1:0] divisor,
    output logic                      done,
    output logic [WORD_BITS-1:0]      quotient
);
    localparam int CNT_W = $clog2(WORD_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] quo_reg;
    logic [WORD_BITS-1:0] dvs_reg;
    logic                 neg_reg;

    logic                 dvd_neg;
    logic                 dvs_neg;
    logic [WORD_BITS-1:0] dvd_mag;
    logic [WORD_BITS-1:0] dvs_mag;
    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS:0]   diff;

    assign dvd_neg = dividend[WORD_BITS-1];
    assign dvs_neg = divisor[WORD_BITS-1];
    assign dvd_mag = dvd_neg ? (~dividend + 1'b1) : dividend;
    assign dvs_mag = dvs_neg ? (~divisor + 1'b1) : divisor;

    assign shifted = {rem_reg, quo_reg[WORD_BITS-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && cnt_reg == '0)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dvd_mag;
            rem_reg <= '0;
            dvs_reg <= dvs_mag;
            neg_reg <= dvd_neg ^ dvs_neg;
            cnt_reg <= CNT_W'(WORD_BITS - 1);
        end
        else if (busy_reg)
        begin
            // trial subtract; keep the partial remainder when it goes negative
            rem_reg <= diff[WORD_BITS] ? shifted[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
            quo_reg <= {quo_reg[WORD_BITS-2:0], ~diff[WORD_BITS]};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a run");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");

endmodule

`default_nettype wire

/* verif/smx_result_checker.sv */
// ----------------------------------------------------------------------------
// smx_result_checker
// Watches both channels of the stack-machine executor, runs a cycle-free model
// of the stack, register file and halt flag on every accepted instruction, and
// compares each accepted result item, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smx_result_checker (
    input  logic  clk,
    input  logic  rst_n,
    smx_instr_if  instr_mon,
    smx_result_if result_mon,
    output int    error_count,
    output int    pending,
    output int    stack_level
);
    import smx_pkg::*;

    logic [VALUE_W-1:0] stack_mem [STACK_DEPTH_DEF];
    logic [VALUE_W-1:0] reg_mem [REG_COUNT_DEF];
    logic               halted;
    result_t            results_due [$];

    function automatic result_t execute_instr(instr_t it);
        result_t            r;
        logic [VALUE_W-1:0] top_w;
        logic [VALUE_W-1:0] nxt_w;
        logic [VALUE_W-1:0] res_w;
        logic [VALUE_W-1:0] mag_top;
        logic [VALUE_W-1:0] mag_nxt;
        logic [VALUE_W-1:0] quo;
        r        = '0;
        r.status = STAT_OK;
        res_w    = '0;
        if (halted) begin
            r.status = STAT_HALT;
        end
        else begin
            case (it.func)
                OP_PUSH:
                begin
                    if (stack_level >= STACK_DEPTH_DEF) begin
                        r.status = STAT_OVER;
                    end
                    else begin
                        stack_mem[stack_level] = it.operand_value;
                        stack_level++;
                    end
                end
                OP_POP:
                begin
                    if (stack_level == 0) begin
                        r.status = STAT_UNDER;
                    end
                    else begin
                        stack_level--;
                        r.pop_valid = 1'b1;
                        r.out_value = stack_mem[stack_level];
                    end
                end
                OP_SET:
                begin
                    // indexes past the register file are dropped silently
                    if (it.reg_index < REG_COUNT_DEF)
                        reg_mem[it.reg_index] = it.operand_value;
                end
                OP_ADD, OP_DIV, OP_AND:
                begin
                    if (stack_level < 2) begin
                        r.status = STAT_UNDER;
                    end
                    else begin
                        top_w = stack_mem[stack_level - 1];
                        nxt_w = stack_mem[stack_level - 2];
                        if (it.func == OP_ADD) begin
                            res_w = top_w + nxt_w;
                        end
                        else if (it.func == OP_AND) begin
                            res_w = (top_w != 0 && nxt_w != 0) ? 1 : 0;
                        end
                        else if (nxt_w == 0) begin
                            r.status = STAT_DIVZ;
                        end
                        else begin
                            // unsigned magnitudes keep most-negative / -1 wrapping
                            mag_top = top_w[VALUE_W-1] ? -top_w : top_w;
                            mag_nxt = nxt_w[VALUE_W-1] ? -nxt_w : nxt_w;
                            quo     = mag_top / mag_nxt;
                            res_w   = (top_w[VALUE_W-1] ^ nxt_w[VALUE_W-1]) ? -quo : quo;
                        end
                        if (r.status == STAT_OK) begin
                            stack_level--;
                            stack_mem[stack_level - 1] = res_w;
                        end
                    end
                end
                OP_HLT:
                begin
                    halted = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        r.depth_now = stack_level[DEPTH_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n) begin
            stack_level = 0;
            halted      = 1'b0;
            error_count = 0;
            for (int i = 0; i < REG_COUNT_DEF; i++)
                reg_mem[i] = '0;
            results_due.delete();
        end
        else begin
            // results first: a result and an instruction in one edge are unrelated
            if (result_mon.valid && result_mon.ready) begin
                got = result_mon.data;
                if (results_due.size() == 0) begin
                    $error("result item with none due: status %0d value %0d depth %0d",
                           got.status, $signed(got.out_value), got.depth_now);
                    error_count++;
                end
                else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.pop_valid !== want.pop_valid) begin
                        $error("pop_valid: expected %0d, got %0d",
                               want.pop_valid, got.pop_valid);
                        error_count++;
                    end
                    if (got.out_value !== want.out_value) begin
                        $error("out_value: expected %0d, got %0d",
                               $signed(want.out_value), $signed(got.out_value));
                        error_count++;
                    end
                    if (got.depth_now !== want.depth_now) begin
                        $error("depth_now: expected %0d, got %0d",
                               want.depth_now, got.depth_now);
                        error_count++;
                    end
                end
            end
            if (instr_mon.valid && instr_mon.ready)
                results_due.push_back(execute_instr(instr_mon.data));
        end
        pending = results_due.size();
    end

endmodule

/* verif/stack_machine_executor_unit_tb.sv */
// ----------------------------------------------------------------------------
// stack_machine_executor_unit_tb
// Drives instruction items into the executor: a directed pass over the corner
// cases, then random traffic that fills the stack to overflow, drains it to
// underflow and mixes all operations, ending with a halt followed by more items. Both channels stall
// in random bursts; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_machine_executor_unit_tb;
    import smx_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;

    logic clk = 1'b0;
    logic rst_n;
    logic quiet;
    int   error_count;
    int   pending;
    int   stack_level;
    int   idle_cycles;

    smx_instr_if  instr_ch ();
    smx_result_if result_ch ();

    stack_machine_executor_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    smx_result_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_mon   (instr_ch),
        .result_mon  (result_ch),
        .error_count (error_count),
        .pending     (pending),
        .stack_level (stack_level)
    );

    always #4 clk = ~clk;

    // receiver back-pressure in short bursts
    initial
    begin : result_stall
        int hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left = $urandom_range(1, 6) - 1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 0;
            3: return -1;
            4, 5: return int'($urandom_range(0, 14)) - 7;
            default: return $urandom();
        endcase
    endfunction

    function automatic instr_t make_instr(func_t f, logic signed [VALUE_W-1:0] v,
                                          int idx);
        instr_t it;
        it.func          = f;
        it.operand_value = v;
        it.reg_index     = IDX_W'(idx);
        return it;
    endfunction

    // never a halt: that one ends the useful part of the run
    function automatic instr_t rand_instr(int push_pct);
        instr_t it;
        it.operand_value = pick_value();
        it.reg_index     = IDX_W'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < push_pct)
        begin
            it.func = OP_PUSH;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: it.func = OP_POP;
                3, 4:    it.func = OP_ADD;
                5:       it.func = OP_DIV;
                6:       it.func = OP_AND;
                7, 8:    it.func = OP_SET;
                default: it.func = OP_NOP;
            endcase
        end
        return it;
    endfunction

    // entered and left at a falling edge
    task automatic send_instr(instr_t it);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.data  <= it;
        @(posedge clk);
        while (!instr_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        instr_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        quiet          = 1'b0;
        idle_cycles    = 0;
        instr_ch.valid = 1'b0;
        instr_ch.data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty-stack underflow, divide by zero, wraps, register set
        send_instr(make_instr(OP_POP, 0, 0));
        send_instr(make_instr(OP_ADD, 0, 0));
        send_instr(make_instr(OP_PUSH, 0, 0));
        send_instr(make_instr(OP_DIV, 0, 0));
        send_instr(make_instr(OP_PUSH, 5, 0));
        send_instr(make_instr(OP_DIV, 0, 0));
        send_instr(make_instr(OP_AND, 0, 0));
        send_instr(make_instr(OP_PUSH, -1, 0));
        send_instr(make_instr(OP_PUSH, 32'sh8000_0000, 0));
        send_instr(make_instr(OP_DIV, 0, 0));
        send_instr(make_instr(OP_PUSH, 7, 0));
        send_instr(make_instr(OP_PUSH, -20, 0));
        send_instr(make_instr(OP_DIV, 0, 0));
        send_instr(make_instr(OP_PUSH, 32'sh7fff_ffff, 0));
        send_instr(make_instr(OP_PUSH, 1, 0));
        send_instr(make_instr(OP_ADD, 0, 0));
        send_instr(make_instr(OP_AND, 0, 0));
        send_instr(make_instr(OP_SET, 32'sh7fff_ffff, 0));
        send_instr(make_instr(OP_SET, 32'sh8000_0000, 5));
        send_instr(make_instr(OP_SET, -1, 6));
        send_instr(make_instr(OP_NOP, -1, 7));
        send_instr(make_instr(OP_POP, 0, 0));
        send_instr(make_instr(OP_POP, 0, 0));
        send_instr(make_instr(OP_PUSH, -1, 7));
        wait_for_results();

        repeat (250) send_instr(rand_instr(45));
        wait_for_results();

        // fill to the top, then push into a full stack
        while (stack_level < STACK_DEPTH_DEF)
            send_instr(rand_instr(85));
        repeat (4) send_instr(make_instr(OP_PUSH, pick_value(), $urandom_range(0, 7)));

        // drain to empty, then keep taking from the empty stack
        while (stack_level > 0)
            send_instr(rand_instr(5));
        repeat (6) send_instr(rand_instr(0));
        wait_for_results();

        repeat (250) send_instr(rand_instr(50));

        quiet = 1'b1;
        repeat (40) send_instr(rand_instr(50));
        send_instr(make_instr(OP_HLT, pick_value(), $urandom_range(0, 7)));
        repeat (8) send_instr(rand_instr(40));
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/smx_pkg.sv
rtl/smx_instr_if.sv
rtl/smx_result_if.sv
rtl/smx_div.sv
rtl/stack_machine_executor_unit.sv
verif/smx_result_checker.sv
verif/stack_machine_executor_unit_tb.sv
